// ----- rtl/fbrf_pkg.sv -----
// Package for the rectangle fill and blit writer.
// Holds opcodes, register indexes, field widths and the shared register struct.
// No dependencies.
package fbrf_pkg;

  localparam int unsigned PixelW    = 32;
  localparam int unsigned AddrW     = 24;
  localparam int unsigned DimRegW   = 13;
  localparam int unsigned RectPosW  = 12;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 32;

  localparam int unsigned ChanW     = 8;
  localparam int unsigned ChanSumW  = 10;
  localparam int unsigned Div3Recip = 683;
  localparam int unsigned Div3Shift = 11;

  typedef enum logic [1:0] {
    OpStart,
    OpFill,
    OpCopy,
    OpGray
  } fbrf_op_e;

  typedef enum logic [CfgIndexW-1:0] {
    RegFillColor,
    RegScreenWidth,
    RegScreenHeight,
    RegLineStride,
    RegRectX,
    RegRectY,
    RegRectWidth,
    RegRectHeight
  } fbrf_reg_e;

  typedef struct packed {
    logic [PixelW-1:0]   fill_color;
    logic [DimRegW-1:0]  screen_width;
    logic [DimRegW-1:0]  screen_height;
    logic [DimRegW-1:0]  line_stride;
    logic [RectPosW-1:0] rect_x;
    logic [RectPosW-1:0] rect_y;
    logic [DimRegW-1:0]  rect_width;
    logic [DimRegW-1:0]  rect_height;
  } fbrf_cfg_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic             done;
  } fbrf_wr_t;

endpackage

// ----- rtl/framebuffer_rect_fill_blit.sv -----
// Top level of the rectangle fill and blit writer with screen-edge clipping.
// Depends on fbrf_pkg, fbrf_cfg, fbrf_walk and fbrf_pix.
//
// The block takes one beat per clock while its output is not stalled and gives
// its result beat in the next cycle from an output register; a new beat is taken in the same cycle as
// the waiting result is taken, so the sustained rate is one beat per cycle
// when the output is not stalled. The path that sets the clock is the
// row-base multiply on a start beat (a 12 by 13 bit product) and the
// grayscale divide by three done as a multiply by a reciprocal.
module framebuffer_rect_fill_blit import fbrf_pkg::*; #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           op_i,
  input  logic [PixelW-1:0]    src_pixel_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 write_enable_o,
  output logic [AddrW-1:0]     write_address_o,
  output logic [PixelW-1:0]    write_pixel_o,
  output logic                 rect_done_o
);

  fbrf_cfg_t         cfg;
  fbrf_wr_t          res;
  fbrf_op_e          op;
  logic [PixelW-1:0] pixel;
  logic              load;

  logic              out_valid_q, out_valid_d;
  logic              we_q, we_d;
  logic [AddrW-1:0]  addr_q, addr_d;
  logic [PixelW-1:0] pix_q, pix_d;
  logic              done_q, done_d;

  assign op         = fbrf_op_e'(op_i);
  assign in_stall_o = out_valid_q && out_stall_i;
  assign load       = in_valid_i && !in_stall_o;

  fbrf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  fbrf_walk #(
    .MAX_DIM (MAX_DIM)
  ) u_walk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (load),
    .op_i      (op),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  fbrf_pix u_pix (
    .op_i         (op),
    .src_pixel_i  (src_pixel_i),
    .fill_color_i (cfg.fill_color),
    .pixel_o      (pixel)
  );

  assign out_valid_d = load || (out_valid_q && out_stall_i);
  assign we_d        = res.we;
  assign addr_d      = res.we ? res.addr : '0;
  assign pix_d       = res.we ? pixel : '0;
  assign done_d      = res.done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      we_q   <= we_d;
      addr_q <= addr_d;
      pix_q  <= pix_d;
      done_q <= done_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign write_enable_o  = we_q;
  assign write_address_o = addr_q;
  assign write_pixel_o   = pix_q;
  assign rect_done_o     = done_q;

  a_empty_never_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> !in_stall_o)
    else $error("Input stalled with an empty output register.");

  a_load_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_q)
    else $error("Accepted beat did not reach the output register.");

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !we_q |-> (addr_q == '0) && (pix_q == '0))
    else $error("Address or pixel non-zero on a beat without a write.");

endmodule

// ----- rtl/fbrf_cfg.sv -----
// Configuration register file of the rectangle writer.
// Depends on fbrf_pkg for the register indexes and the register struct.
module fbrf_cfg import fbrf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  output fbrf_cfg_t            cfg_o
);

  fbrf_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (fbrf_reg_e'(cfg_index_i))
        RegFillColor:    cfg_d.fill_color    = cfg_wdata_i[PixelW-1:0];
        RegScreenWidth:  cfg_d.screen_width  = cfg_wdata_i[DimRegW-1:0];
        RegScreenHeight: cfg_d.screen_height = cfg_wdata_i[DimRegW-1:0];
        RegLineStride:   cfg_d.line_stride   = cfg_wdata_i[DimRegW-1:0];
        RegRectX:        cfg_d.rect_x        = cfg_wdata_i[RectPosW-1:0];
        RegRectY:        cfg_d.rect_y        = cfg_wdata_i[RectPosW-1:0];
        RegRectWidth:    cfg_d.rect_width    = cfg_wdata_i[DimRegW-1:0];
        RegRectHeight:   cfg_d.rect_height   = cfg_wdata_i[DimRegW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/fbrf_pix.sv -----
// Pixel selection of the rectangle writer: fill colour, copy or grayscale.
// Depends on fbrf_pkg for the opcodes and the divide-by-three constants.
module fbrf_pix import fbrf_pkg::*; (
  input  fbrf_op_e          op_i,
  input  logic [PixelW-1:0] src_pixel_i,
  input  logic [PixelW-1:0] fill_color_i,
  output logic [PixelW-1:0] pixel_o
);

  localparam int unsigned ProdW = ChanSumW + ChanSumW;

  logic [ChanSumW-1:0] sum;
  logic [ProdW-1:0]    prod;
  logic [ChanW-1:0]    avg;

  assign sum  = ChanSumW'(src_pixel_i[7:0]) + ChanSumW'(src_pixel_i[15:8])
              + ChanSumW'(src_pixel_i[23:16]);
  assign prod = ProdW'(sum) * ProdW'(Div3Recip);
  assign avg  = prod[Div3Shift +: ChanW];

  always_comb begin
    case (op_i)
      OpFill:  pixel_o = fill_color_i;
      OpCopy:  pixel_o = src_pixel_i;
      OpGray:  pixel_o = {src_pixel_i[31:24], avg, avg, avg};
      default: pixel_o = '0;
    endcase
  end

endmodule

// ----- rtl/fbrf_walk.sv -----
// Rectangle walk of the writer: column and row counters, incremental row base,
// clipping and the write address. Depends on fbrf_pkg.
module fbrf_walk import fbrf_pkg::*; #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      advance_i,
  input  fbrf_op_e  op_i,
  input  fbrf_cfg_t cfg_i,
  output fbrf_wr_t  res_o
);

  localparam int unsigned DimW  = $clog2(MAX_DIM + 1);
  localparam int unsigned CmpW  = (DimW > DimRegW) ? DimW : DimRegW;
  localparam int unsigned SumW  = ((DimW > RectPosW) ? DimW : RectPosW) + 1;
  localparam int unsigned ProdW = RectPosW + DimW;

  function automatic logic [DimW-1:0] sat_dim(input logic [DimRegW-1:0] v);
    logic [CmpW-1:0] ve;
    begin
      ve = CmpW'(v);
      if (ve > CmpW'(MAX_DIM)) begin
        return DimW'(MAX_DIM);
      end
      return DimW'(v);
    end
  endfunction

  logic [DimW-1:0]  column_q, column_d;
  logic [DimW-1:0]  row_q, row_d;
  logic [AddrW-1:0] row_base_q, row_base_d;
  logic             finished_q, finished_d;

  logic [DimW-1:0]  rw, rh, sw, sh, stride;
  logic [SumW-1:0]  sx, sy;
  logic [DimW-1:0]  col_inc, row_inc;
  logic [ProdW-1:0] start_prod;
  logic             is_start, empty, visible, wrap, last;

  assign rw     = sat_dim(cfg_i.rect_width);
  assign rh     = sat_dim(cfg_i.rect_height);
  assign sw     = sat_dim(cfg_i.screen_width);
  assign sh     = sat_dim(cfg_i.screen_height);
  assign stride = sat_dim(cfg_i.line_stride);

  assign is_start   = (op_i == OpStart);
  assign empty      = (rw == '0) || (rh == '0);
  assign start_prod = ProdW'(cfg_i.rect_y) * ProdW'(stride);

  assign sx      = SumW'(cfg_i.rect_x) + SumW'(column_q);
  assign sy      = SumW'(cfg_i.rect_y) + SumW'(row_q);
  assign visible = (sx < SumW'(sw)) && (sy < SumW'(sh));
  assign col_inc = column_q + DimW'(1);
  assign row_inc = row_q + DimW'(1);
  assign wrap    = (col_inc >= rw);
  assign last    = wrap && (row_inc >= rh);

  assign res_o.we   = !is_start && !finished_q && visible;
  assign res_o.addr = row_base_q + AddrW'(sx);
  assign res_o.done = is_start ? empty : (!finished_q && last);

  always_comb begin
    column_d   = column_q;
    row_d      = row_q;
    row_base_d = row_base_q;
    finished_d = finished_q;
    if (advance_i) begin
      if (is_start) begin
        column_d   = '0;
        row_d      = '0;
        row_base_d = AddrW'(start_prod);
        finished_d = empty;
      end else if (!finished_q) begin
        column_d = wrap ? '0 : col_inc;
        if (wrap) begin
          row_d      = row_inc;
          row_base_d = row_base_q + AddrW'(stride);
          finished_d = last;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q   <= '0;
      row_q      <= '0;
      row_base_q <= '0;
      finished_q <= 1'b1;
    end else begin
      column_q   <= column_d;
      row_q      <= row_d;
      row_base_q <= row_base_d;
      finished_q <= finished_d;
    end
  end

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && is_start |=> (column_q == '0) && (row_q == '0))
    else $error("Counters not cleared after a start beat.");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && !is_start && finished_q |=>
      finished_q && $stable(column_q) && $stable(row_q) && $stable(row_base_q))
    else $error("Walk state moved while finished.");

  a_last_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && !is_start && !finished_q && last |=> finished_q && (column_q == '0))
    else $error("Walk did not finish after the last position.");

endmodule

// ----- verif/tb_framebuffer_rect_fill_blit.sv -----
// Self-checking testbench for framebuffer_rect_fill_blit: directed rectangles, then random ones.
// A small class predicts every write beat and compares it with what the block returns.
// Depends on fbrf_pkg and the RTL of framebuffer_rect_fill_blit only.
module tb_framebuffer_rect_fill_blit;
  timeunit 1ns;
  timeprecision 1ps;
  import fbrf_pkg::*;

  localparam int unsigned MaxDim     = 4096;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandBeats  = 1000;

  typedef struct packed {
    logic              we;
    logic [AddrW-1:0]  addr;
    logic [PixelW-1:0] pixel;
    logic              done;
  } fb_write_t;

  class pixel_write_checker;
    fbrf_cfg_t          regs;
    logic [DimRegW-1:0] column;
    logic [DimRegW-1:0] row;
    logic [AddrW-1:0]   row_base;
    bit                 finished;
    fb_write_t          expected_writes[$];
    int                 errors;

    function new();
      regs     = '0;
      column   = '0;
      row      = '0;
      row_base = '0;
      finished = 1'b1;
      errors   = 0;
    endfunction

    function void set_reg(fbrf_reg_e idx, logic [CfgDataW-1:0] value);
      case (idx)
        RegFillColor:    regs.fill_color    = value;
        RegScreenWidth:  regs.screen_width  = value[DimRegW-1:0];
        RegScreenHeight: regs.screen_height = value[DimRegW-1:0];
        RegLineStride:   regs.line_stride   = value[DimRegW-1:0];
        RegRectX:        regs.rect_x        = value[RectPosW-1:0];
        RegRectY:        regs.rect_y        = value[RectPosW-1:0];
        RegRectWidth:    regs.rect_width    = value[DimRegW-1:0];
        default:         regs.rect_height   = value[DimRegW-1:0];
      endcase
    endfunction

    function int unsigned clamp_dim(logic [DimRegW-1:0] v);
      return (32'(v) > MaxDim) ? MaxDim : 32'(v);
    endfunction

    function logic [PixelW-1:0] gray_of(logic [PixelW-1:0] p);
      int unsigned avg;
      avg = (int'(p[7:0]) + int'(p[15:8]) + int'(p[23:16])) / 3;
      return {p[31:24], avg[7:0], avg[7:0], avg[7:0]};
    endfunction

    function fb_write_t predict_write(fbrf_op_e op, logic [PixelW-1:0] src);
      fb_write_t   w;
      int unsigned rw;
      int unsigned rh;
      int unsigned stride;
      int unsigned sx;
      int unsigned sy;
      w      = '0;
      rw     = clamp_dim(regs.rect_width);
      rh     = clamp_dim(regs.rect_height);
      stride = clamp_dim(regs.line_stride);
      if (op == OpStart) begin
        column   = '0;
        row      = '0;
        row_base = AddrW'(32'(regs.rect_y) * stride);
        finished = (rw == 0 || rh == 0);
        w.done   = finished;
      end else if (!finished) begin
        sx = 32'(regs.rect_x) + 32'(column);
        sy = 32'(regs.rect_y) + 32'(row);
        if (sx < clamp_dim(regs.screen_width) && sy < clamp_dim(regs.screen_height)) begin
          w.we   = 1'b1;
          w.addr = AddrW'(32'(row_base) + sx);
          case (op)
            OpFill:  w.pixel = regs.fill_color;
            OpCopy:  w.pixel = src;
            default: w.pixel = gray_of(src);
          endcase
        end
        column = column + DimRegW'(1);
        if (32'(column) >= rw) begin
          column   = '0;
          row      = row + DimRegW'(1);
          row_base = AddrW'(32'(row_base) + stride);
          if (32'(row) >= rh) begin
            finished = 1'b1;
            w.done   = 1'b1;
          end
        end
      end
      return w;
    endfunction

    function void note_input(fbrf_op_e op, logic [PixelW-1:0] src);
      expected_writes.push_back(predict_write(op, src));
    endfunction

    function int pending_count();
      return expected_writes.size();
    endfunction

    task report_mismatch(string msg);
      if (errors < 40) begin
        $display("MISMATCH at %0t: %s", $realtime, msg);
      end
      errors++;
    endtask

    task check_write(fb_write_t got);
      fb_write_t want;
      if (expected_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected beat we=%0b addr=%h pixel=%h done=%0b",
                                  got.we, got.addr, got.pixel, got.done));
        return;
      end
      want = expected_writes.pop_front();
      if (got.we !== want.we) begin
        report_mismatch($sformatf("write_enable %0b, want %0b", got.we, want.we));
      end
      if (got.addr !== want.addr) begin
        report_mismatch($sformatf("write_address %h, want %h", got.addr, want.addr));
      end
      if (got.pixel !== want.pixel) begin
        report_mismatch($sformatf("write_pixel %h, want %h", got.pixel, want.pixel));
      end
      if (got.done !== want.done) begin
        report_mismatch($sformatf("rect_done %0b, want %0b", got.done, want.done));
      end
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CfgIndexW-1:0] cfg_index_i = RegFillColor;
  logic [CfgDataW-1:0]  cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           op_i        = OpStart;
  logic [PixelW-1:0]    src_pixel_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 write_enable_o;
  logic [AddrW-1:0]     write_address_o;
  logic [PixelW-1:0]    write_pixel_o;
  logic                 rect_done_o;

  pixel_write_checker write_chk = new();
  int unsigned        cycle_count = 0;
  int unsigned        burst_left  = 0;
  int unsigned        stall_left  = 0;
  int unsigned        stall_mode  = 0;
  int unsigned        beats_sent  = 0;

  framebuffer_rect_fill_blit #(
    .MAX_DIM(MaxDim)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .src_pixel_i    (src_pixel_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .write_enable_o (write_enable_o),
    .write_address_o(write_address_o),
    .write_pixel_o  (write_pixel_o),
    .rect_done_o    (rect_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("RESULT: ERROR");
    $finish;
  end

  // The receiver switches between stall patterns at random intervals.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(10, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= (stall_left[1:0] == 2'd0);
      default: out_stall_i <= ($urandom_range(0, 1) == 1);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        write_chk.note_input(fbrf_op_e'(op_i), src_pixel_i);
      end
      if (out_valid_o && !out_stall_i) begin
        write_chk.check_write(fb_write_t'{we: write_enable_o, addr: write_address_o,
                                          pixel: write_pixel_o, done: rect_done_o});
      end
    end
  end

  task automatic send_beat(fbrf_op_e op, logic [PixelW-1:0] pixel);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    op_i        <= op;
    src_pixel_i <= pixel;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (write_chk.pending_count() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(fbrf_reg_e idx, logic [CfgDataW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    write_chk.set_reg(idx, value);
  endtask

  task automatic load_regs(logic [CfgDataW-1:0] fill, logic [CfgDataW-1:0] sw,
                           logic [CfgDataW-1:0] sh, logic [CfgDataW-1:0] stride,
                           logic [CfgDataW-1:0] x, logic [CfgDataW-1:0] y,
                           logic [CfgDataW-1:0] w, logic [CfgDataW-1:0] h);
    write_reg(RegFillColor, fill);
    write_reg(RegScreenWidth, sw);
    write_reg(RegScreenHeight, sh);
    write_reg(RegLineStride, stride);
    write_reg(RegRectX, x);
    write_reg(RegRectY, y);
    write_reg(RegRectWidth, w);
    write_reg(RegRectHeight, h);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CfgDataW-1:0] pick_screen_dim();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return MaxDim;
      2:       return 8191;
      3:       return $urandom_range(MaxDim + 1, 8191);
      default: return $urandom_range(1, 24);
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] pick_rect_dim();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return 8191;
      2:       return MaxDim;
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic logic [PixelW-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_setup();
    logic [CfgDataW-1:0] v;
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        case (fbrf_reg_e'(i)) inside
          RegFillColor:                    v = $urandom;
          RegScreenWidth, RegScreenHeight: v = pick_screen_dim();
          RegLineStride: begin
            v = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 8191) : $urandom_range(0, 32);
          end
          RegRectX, RegRectY: begin
            v = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 20);
          end
          default:                         v = pick_rect_dim();
        endcase
        if (fbrf_reg_e'(i) != RegFillColor && $urandom_range(0, 4) == 0) begin
          v[CfgDataW-1:RectPosW] = (CfgDataW-RectPosW)'($urandom);
        end
        write_reg(fbrf_reg_e'(i), v);
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_walks();
    int unsigned area;
    int unsigned steps;
    fbrf_op_e    op;
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 9) != 0) begin
        send_beat(OpStart, pick_pixel());
      end
      area  = write_chk.clamp_dim(write_chk.regs.rect_width) *
              write_chk.clamp_dim(write_chk.regs.rect_height);
      steps = (area > 40) ? $urandom_range(10, 40) : area + $urandom_range(0, 3);
      repeat (steps) begin
        op = ($urandom_range(0, 29) == 0) ? OpStart : fbrf_op_e'($urandom_range(1, 3));
        send_beat(op, pick_pixel());
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Steps before any start are ignored; a start with all registers zero is empty.
    send_beat(OpFill, 32'h1234_5678);
    send_beat(OpGray, 32'hFFFF_FFFF);
    send_beat(OpStart, '0);
    wait_idle();

    // Right-edge and bottom-edge clipping, oversized stride, every pixel operation.
    load_regs(32'hFFFF_FFFF, 4, 2, 8191, 2, 1, 3, 2);
    send_beat(OpStart, '0);
    send_beat(OpFill, '0);
    send_beat(OpCopy, 32'hFFFF_FFFF);
    send_beat(OpGray, 32'h00FF_8001);
    send_beat(OpGray, 32'hFFFF_FFFF);
    send_beat(OpCopy, '0);
    send_beat(OpFill, 32'hFFFF_FFFF);
    send_beat(OpCopy, 32'hA5A5_5A5A);
    wait_idle();

    // Largest position and oversized dimensions, reaching the top of the address range.
    load_regs('0, 8191, 8191, MaxDim, 4094, 4095, 8191, 1);
    send_beat(OpStart, '0);
    send_beat(OpCopy, 32'hAAAA_AAAA);
    send_beat(OpGray, 32'h80FF_FFFF);
    send_beat(OpFill, '0);
    wait_idle();

    // Rectangle starting at the screen's right edge: whole row clipped.
    load_regs(32'h5555_AAAA, 5, MaxDim, 7, 5, 0, 2, 1);
    send_beat(OpStart, '0);
    send_beat(OpFill, '0);
    send_beat(OpCopy, 32'h0F0F_F0F0);
    wait_idle();

    write_reg(RegRectWidth, 0);
    write_reg(RegRectHeight, 5);
    cfg_we_i <= 1'b0;
    send_beat(OpStart, '0);
    send_beat(OpGray, 32'h1234_5678);

    while (beats_sent < RandBeats + 20) begin
      wait_idle();
      random_setup();
      random_walks();
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (write_chk.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/fbrf_pkg.sv
rtl/fbrf_cfg.sv
rtl/fbrf_pix.sv
rtl/fbrf_walk.sv
rtl/framebuffer_rect_fill_blit.sv
verif/tb_framebuffer_rect_fill_blit.sv
